// ----- hw/rtl/word_frequency_counter_assert.svh -----
// ----------------------------------------------------------------------------
// word frequency counter assertion macros
// shorthand for the concurrent checks kept at the end of the top level
// ----------------------------------------------------------------------------
`ifndef WORD_FREQUENCY_COUNTER_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_ASSERT_SVH

// condition holds at every edge out of reset
`define WFC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define WFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/wfc_pkg.sv -----
// ----------------------------------------------------------------------------
// wfc_pkg
// shared types, constants and character helpers of the word frequency counter
// ----------------------------------------------------------------------------
`default_nettype none

package wfc_pkg;

  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 6;
  localparam int CNT_W           = 11;
  localparam int IDX_W           = 10;
  localparam int ENTRY_SLOTS     = 1024;
  localparam int TALLY_MAX       = 2047;
  localparam int RESULT_CAP      = 32;
  localparam int WORD_CHARS_DEF  = 32;
  localparam int TOKEN_LIMIT_DEF = 1024;
  localparam int ENT_W_DEF       = WORD_CHARS_DEF * CHAR_W + LEN_W + CNT_W;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_END  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_FLAG,
    S_RLOAD,
    S_STREAM
  } state_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic [CHAR_W-1:0] tok_char;
    logic              rd_load;
    logic              rd_shift;
  } cell_ctl_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] b);
    is_space = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] b);
    to_lower = ((b >= 8'd65) && (b <= 8'd90)) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] b);
    is_alnum = ((b >= 8'd48) && (b <= 8'd57)) || ((b >= 8'd97) && (b <= 8'd122));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wfc_if.sv -----
// ----------------------------------------------------------------------------
// wfc interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface wfc_req_if
  import wfc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CHAR_W-1:0] text_byte;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, action, text_byte, entry_index, input ready);
  modport sink   (input valid, action, text_byte, entry_index, output ready);
endinterface

interface wfc_rsp_if
  import wfc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic [CNT_W-1:0]  entry_count;
  logic              entry_valid;
  logic [CNT_W-1:0]  distinct_total;
  logic              last;

  modport source (output valid, out_char, entry_count, entry_valid, distinct_total, last,
                  input ready);
  modport sink   (input valid, out_char, entry_count, entry_valid, distinct_total, last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wfc_cell.sv -----
// ----------------------------------------------------------------------------
// wfc_cell
// one character position: holds a token char, compares it against a table
// row char, and holds a readout char that shifts toward cell zero
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_cell
  import wfc_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic              tok_we,
  input  wire logic [CHAR_W-1:0] row_char,
  input  wire logic [CHAR_W-1:0] shift_in,
  input  wire logic              active,
  output logic      [CHAR_W-1:0] tok,
  output logic      [CHAR_W-1:0] rd,
  output logic                   match
);

  // token character capture
  always_ff @(posedge clk) begin
    if (tok_we) begin
      tok <= ctl.tok_char;
    end
  end

  // readout: parallel load from a row, then shift one place per item
  always_ff @(posedge clk) begin
    if (ctl.rd_load) begin
      rd <= row_char;
    end else if (ctl.rd_shift) begin
      rd <= shift_in;
    end
  end

  // positions past the token length always agree
  assign match = !active || (tok == row_char);

endmodule

`default_nettype wire

// ----- hw/rtl/wfc_table.sv -----
// ----------------------------------------------------------------------------
// wfc_table
// distinct word table: one row per entry holding chars, length and tally
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_table
  import wfc_pkg::*;
#(
  parameter int ENT_W = ENT_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [ENT_W-1:0] wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [ENTRY_SLOTS];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/word_frequency_counter.sv -----
// ----------------------------------------------------------------------------
// word_frequency_counter
// tallies distinct words of a byte stream and reads stored words back
// ----------------------------------------------------------------------------
// A text byte that closes no counted token leaves the counter in S_IDLE,
// ready for the next request. A closing token walks the D distinct words
// one entry at a time: S_SEARCH reads the row, S_CMP compares it in the
// row of character cells. End of text adds a status item from S_FLAG. A
// read loads the fetched row into the cells in S_RLOAD, then S_STREAM gives
// one character item whenever the result slot is free. The table needs no
// clearing pass after reset: only entries below the distinct count are read.
`default_nettype none

`include "word_frequency_counter_assert.svh"

module word_frequency_counter
  import wfc_pkg::*;
#(
  parameter int WORD_CHARS  = WORD_CHARS_DEF,
  parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wfc_req_if.sink   req,
  wfc_rsp_if.source rsp
);

  localparam int ROW_W  = WORD_CHARS * CHAR_W;
  localparam int ENT_W  = ROW_W + LEN_W + CNT_W;
  localparam int TK_W   = $clog2(TOKEN_LIMIT + 1);
  localparam int RD_CAP = (WORD_CHARS < RESULT_CAP) ? WORD_CHARS : RESULT_CAP;

  state_t            state, state_next;
  logic              in_token, in_token_next;
  logic [LEN_W-1:0]  clean_len, clean_len_next;
  logic [LEN_W-1:0]  raw_len, raw_len_next;
  logic [TK_W-1:0]   tokens, tokens_next;
  logic [CNT_W-1:0]  distinct, distinct_next;
  logic [LEN_W-1:0]  tok_len, tok_len_next;
  logic [CNT_W-1:0]  e, e_next;
  logic              eot_pend, eot_pend_next;
  logic [LEN_W-1:0]  rlen, rlen_next;
  logic [LEN_W-1:0]  k, k_next;
  logic [CNT_W-1:0]  rtally, rtally_next;

  logic              rsp_valid;
  logic [CHAR_W-1:0] rsp_char;
  logic [CNT_W-1:0]  rsp_count;
  logic              rsp_evalid;
  logic [CNT_W-1:0]  rsp_total;
  logic              rsp_last;

  logic              out_load;
  logic [CHAR_W-1:0] out_char_n;
  logic [CNT_W-1:0]  out_count_n;
  logic              out_evalid_n;
  logic              out_last_n;
  logic              slot_free;

  logic              tab_we;
  logic [IDX_W-1:0]  tab_waddr;
  logic [ENT_W-1:0]  tab_wdata;
  logic [IDX_W-1:0]  tab_raddr;
  logic [ENT_W-1:0]  tab_rdata;
  logic [ROW_W-1:0]  row_chars;
  logic [LEN_W-1:0]  row_len;
  logic [CNT_W-1:0]  row_tally;
  logic [LEN_W-1:0]  row_len_cap;

  cell_ctl_t         ctl;
  logic              tok_we;
  logic [LEN_W-1:0]  tok_pos;
  logic [ROW_W-1:0]  tok_vec;
  logic [CHAR_W-1:0] rd_a [WORD_CHARS];
  logic [WORD_CHARS-1:0] match_v;
  logic              all_match;

  logic              accept;
  logic [CHAR_W-1:0] lc;
  logic [LEN_W-1:0]  close_len;
  logic              do_close;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;

  assign row_chars   = tab_rdata[ENT_W-1 -: ROW_W];
  assign row_len     = tab_rdata[CNT_W +: LEN_W];
  assign row_tally   = tab_rdata[CNT_W-1:0];
  assign row_len_cap = (row_len > LEN_W'(RD_CAP)) ? LEN_W'(RD_CAP) : row_len;
  assign all_match   = &match_v;
  assign tab_raddr   = (state == S_IDLE) ? req.entry_index : e[IDX_W-1:0];

  // distinct word table
  wfc_table #(
    .ENT_W(ENT_W)
  ) u_table (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  // row of character cells
  for (genvar i = 0; i < WORD_CHARS; i++) begin : g_cell
    logic [CHAR_W-1:0] tok_i;
    logic [CHAR_W-1:0] shift_in_i;

    if (i == WORD_CHARS - 1) begin : g_end
      assign shift_in_i = '0;
    end else begin : g_mid
      assign shift_in_i = rd_a[i+1];
    end

    wfc_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .tok_we  (tok_we && (tok_pos == LEN_W'(i))),
      .row_char(row_chars[i*CHAR_W +: CHAR_W]),
      .shift_in(shift_in_i),
      .active  (LEN_W'(i) < tok_len),
      .tok     (tok_i),
      .rd      (rd_a[i]),
      .match   (match_v[i])
    );

    assign tok_vec[i*CHAR_W +: CHAR_W] = tok_i;
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_token  <= 1'b0;
      clean_len <= '0;
      raw_len   <= '0;
      tokens    <= '0;
      distinct  <= '0;
      eot_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_token  <= in_token_next;
      clean_len <= clean_len_next;
      raw_len   <= raw_len_next;
      tokens    <= tokens_next;
      distinct  <= distinct_next;
      eot_pend  <= eot_pend_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    tok_len <= tok_len_next;
    e       <= e_next;
    rlen    <= rlen_next;
    k       <= k_next;
    rtally  <= rtally_next;
    if (out_load) begin
      rsp_char   <= out_char_n;
      rsp_count  <= out_count_n;
      rsp_evalid <= out_evalid_n;
      rsp_total  <= distinct;
      rsp_last   <= out_last_n;
    end
  end

  // next state, table access and cell control
  always_comb begin
    state_next     = state;
    in_token_next  = in_token;
    clean_len_next = clean_len;
    raw_len_next   = raw_len;
    tokens_next    = tokens;
    distinct_next  = distinct;
    tok_len_next   = tok_len;
    e_next         = e;
    eot_pend_next  = eot_pend;
    rlen_next      = rlen;
    k_next         = k;
    rtally_next    = rtally;
    out_load       = 1'b0;
    out_char_n     = '0;
    out_count_n    = '0;
    out_evalid_n   = 1'b0;
    out_last_n     = 1'b1;
    tab_we         = 1'b0;
    tab_waddr      = distinct[IDX_W-1:0];
    tab_wdata      = {tok_vec, tok_len, CNT_W'(1)};
    lc             = to_lower(req.text_byte);
    ctl.tok_char   = lc;
    ctl.rd_load    = 1'b0;
    ctl.rd_shift   = 1'b0;
    tok_we         = 1'b0;
    tok_pos        = clean_len;
    close_len      = clean_len;
    do_close       = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (act_t'(req.action))
            ACT_BYTE: begin
              if (is_space(req.text_byte)) begin
                do_close = in_token;
              end else begin
                in_token_next = 1'b1;
                if (is_alnum(lc) && (clean_len < LEN_W'(WORD_CHARS))) begin
                  tok_we    = 1'b1;
                  close_len = clean_len + LEN_W'(1);
                end
                raw_len_next = raw_len + LEN_W'(1);
                clean_len_next = close_len;
                do_close = (raw_len + LEN_W'(1)) >= LEN_W'(WORD_CHARS);
              end
            end
            ACT_END: begin
              do_close   = in_token;
              state_next = S_FLAG;
            end
            ACT_READ: begin
              if ({1'b0, req.entry_index} >= distinct) begin
                state_next = S_FLAG;
              end else begin
                state_next = S_RLOAD;
              end
            end
            default: begin
            end
          endcase

          // close the open token, start a table walk if it is counted
          if (do_close) begin
            in_token_next  = 1'b0;
            raw_len_next   = '0;
            clean_len_next = '0;
            if ((close_len != '0) && (tokens != TK_W'(TOKEN_LIMIT))) begin
              tokens_next   = tokens + TK_W'(1);
              tok_len_next  = close_len;
              e_next        = '0;
              eot_pend_next = (act_t'(req.action) == ACT_END);
              state_next    = S_SEARCH;
            end
          end
        end
      end

      S_SEARCH: begin
        if (e == distinct) begin
          // no match: append while room remains
          if (distinct != CNT_W'(ENTRY_SLOTS)) begin
            tab_we        = 1'b1;
            distinct_next = distinct + CNT_W'(1);
          end
          state_next    = eot_pend ? S_FLAG : S_IDLE;
          eot_pend_next = 1'b0;
        end else begin
          state_next = S_CMP;
        end
      end

      S_CMP: begin
        if ((row_len == tok_len) && all_match) begin
          tab_we        = 1'b1;
          tab_waddr     = e[IDX_W-1:0];
          tab_wdata     = {row_chars, row_len,
                           (row_tally == CNT_W'(TALLY_MAX)) ? row_tally
                                                            : row_tally + CNT_W'(1)};
          state_next    = eot_pend ? S_FLAG : S_IDLE;
          eot_pend_next = 1'b0;
        end else begin
          e_next     = e + CNT_W'(1);
          state_next = S_SEARCH;
        end
      end

      S_FLAG: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_RLOAD: begin
        ctl.rd_load = 1'b1;
        rlen_next   = row_len_cap;
        rtally_next = row_tally;
        k_next      = '0;
        state_next  = S_STREAM;
      end

      S_STREAM: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_n   = (rlen == '0) ? '0 : rd_a[0];
          out_count_n  = rtally;
          out_evalid_n = 1'b1;
          out_last_n   = (rlen == '0) ||
                         (({1'b0, k} + (LEN_W+1)'(1)) == {1'b0, rlen});
          ctl.rd_shift = 1'b1;
          k_next       = k + LEN_W'(1);
          if (out_last_n) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result channel
  assign rsp.valid          = rsp_valid;
  assign rsp.out_char       = rsp_char;
  assign rsp.entry_count    = rsp_count;
  assign rsp.entry_valid    = rsp_evalid;
  assign rsp.distinct_total = rsp_total;
  assign rsp.last           = rsp_last;

  // checks
  `WFC_ASSERT_ALWAYS(a_distinct_cap, distinct <= CNT_W'(ENTRY_SLOTS), "distinct count over table size")
  `WFC_ASSERT_NEXT(a_distinct_step, 1'b1, (distinct == $past(distinct)) || (distinct == $past(distinct) + CNT_W'(1)), "distinct count jumped")
  `WFC_ASSERT_IMP(a_walk_bound, (state == S_SEARCH) || (state == S_CMP), (e <= distinct) && (tok_len != '0), "table walk out of range")
  `WFC_ASSERT_IMP(a_empty_item, rsp_valid && !rsp_evalid, (rsp_count == '0) && (rsp_char == '0) && rsp_last, "status item carries data")

endmodule

`default_nettype wire

// ----- test/word_frequency_counter_tb.sv -----
// ----------------------------------------------------------------------------
// word_frequency_counter_tb
// streams text bytes, end-of-text markers and entry reads into the counter,
// tracks the distinct-word table alongside it and checks every streamed item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module word_frequency_counter_tb;
  import wfc_pkg::*;

  localparam int WCH       = WORD_CHARS_DEF;
  localparam int TLIMIT    = TOKEN_LIMIT_DEF;
  localparam int IDLE_STOP = 20000;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAR_W-1:0] text_byte;
    logic [IDX_W-1:0]  entry_index;
  } req_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [CNT_W-1:0]  entry_count;
    logic              entry_valid;
    logic [CNT_W-1:0]  distinct_total;
    logic              last;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wfc_req_if req ();
  wfc_rsp_if rsp ();

  word_frequency_counter u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #5 clk = ~clk;

  // shadow copy of the word table
  logic [CHAR_W-1:0] tbl_chars [ENTRY_SLOTS][WCH];
  int                tbl_len   [ENTRY_SLOTS];
  int                tbl_tally [ENTRY_SLOTS];
  int                n_distinct;
  int                n_tokens;
  logic [CHAR_W-1:0] tok_chars [WCH];
  int                tok_clean;
  int                tok_raw;
  bit                tok_open;

  req_item_t pending_reqs [$];
  rsp_item_t expected_rsps [$];
  bit        stim_done = 1'b0;
  int        mismatches = 0;
  int        idle_cycles = 0;

  function automatic bit is_ws(logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic close_word();
    int  len;
    bit  same;
    len = tok_clean;
    tok_open = 1'b0;
    tok_raw = 0;
    tok_clean = 0;
    if (len == 0 || n_tokens >= TLIMIT) return;
    n_tokens++;
    for (int e = 0; e < n_distinct; e++) begin
      same = (tbl_len[e] == len);
      for (int k = 0; k < len; k++)
        if (tbl_chars[e][k] != tok_chars[k]) same = 1'b0;
      if (same) begin
        if (tbl_tally[e] < TALLY_MAX) tbl_tally[e]++;
        return;
      end
    end
    if (n_distinct < ENTRY_SLOTS) begin
      for (int k = 0; k < len; k++) tbl_chars[n_distinct][k] = tok_chars[k];
      tbl_len[n_distinct] = len;
      tbl_tally[n_distinct] = 1;
      n_distinct++;
    end
  endtask

  function automatic rsp_item_t mk_rsp(logic [7:0] ch, int cnt, bit vld, bit lst);
    rsp_item_t r;
    r.out_char = ch;
    r.entry_count = cnt[CNT_W-1:0];
    r.entry_valid = vld;
    r.distinct_total = n_distinct[CNT_W-1:0];
    r.last = lst;
    return r;
  endfunction

  // work out the items caused by one accepted request
  task automatic predict_counter(req_item_t it);
    logic [7:0] b;
    int         len;
    case (act_t'(it.action))
      ACT_BYTE: begin
        b = it.text_byte;
        if (is_ws(b)) begin
          if (tok_open) close_word();
        end else begin
          tok_open = 1'b1;
          if (b >= 8'd65 && b <= 8'd90) b = b + 8'd32;
          if (((b >= 8'd48 && b <= 8'd57) || (b >= 8'd97 && b <= 8'd122)) && tok_clean < WCH)
          begin
            tok_chars[tok_clean] = b;
            tok_clean++;
          end
          tok_raw++;
          if (tok_raw >= WCH) close_word();
        end
      end
      ACT_END: begin
        if (tok_open) close_word();
        expected_rsps.push_back(mk_rsp(8'd0, 0, 1'b0, 1'b1));
      end
      ACT_READ: begin
        if (it.entry_index >= n_distinct) begin
          expected_rsps.push_back(mk_rsp(8'd0, 0, 1'b0, 1'b1));
        end else begin
          len = tbl_len[it.entry_index];
          for (int k = 0; k < len; k++)
            expected_rsps.push_back(mk_rsp(tbl_chars[it.entry_index][k],
                                           tbl_tally[it.entry_index], 1'b1, k == len - 1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req.ready) begin
      // hold
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      req.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      req_item_t it;
      it = pending_reqs.pop_front();
      req.valid <= 1'b1;
      req.action <= it.action;
      req.text_byte <= it.text_byte;
      req.entry_index <= it.entry_index;
      src_gap <= gap_len();
    end else begin
      req.valid <= 1'b0;
    end
  end

  // sink stalls
  int snk_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      snk_gap <= gap_len();
    end
  end

  // monitor: predict on request accept, compare on result accept
  always @(posedge clk) begin
    rsp_item_t got, exp_r;
    if (!rst) begin
      if (req.valid && req.ready) predict_counter({req.action, req.text_byte, req.entry_index});
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        got = {rsp.out_char, rsp.entry_count, rsp.entry_valid, rsp.distinct_total, rsp.last};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp char %h cnt %0d vld %b tot %0d last %b, got char %h cnt %0d vld %b tot %0d last %b",
                       exp_r.out_char, exp_r.entry_count, exp_r.entry_valid,
                       exp_r.distinct_total, exp_r.last, got.out_char, got.entry_count,
                       got.entry_valid, got.distinct_total, got.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= IDLE_STOP) begin
      $display("word_frequency_counter_tb NOT OK");
      $finish;
    end
  end

  function automatic req_item_t mk_req(act_t a, logic [7:0] b, logic [9:0] idx);
    req_item_t r;
    r.action = a;
    r.text_byte = b;
    r.entry_index = idx;
    return r;
  endfunction

  task automatic push_word(string s);
    for (int i = 0; i < s.len(); i++) pending_reqs.push_back(mk_req(ACT_BYTE, s[i], 10'd0));
  endtask

  // random well-formed word from a small vocabulary, sometimes noisy
  task automatic push_random_word();
    string vocab [6] = '{"the", "Cat", "a1", "DOG", "zz9", "The"};
    logic [7:0] seps [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6))
        pending_reqs.push_back(mk_req(ACT_BYTE, 8'($urandom_range(0, 255)), 10'd0));
    end else begin
      push_word(vocab[$urandom_range(0, 5)]);
    end
    pending_reqs.push_back(mk_req(ACT_BYTE, seps[$urandom_range(0, 5)], 10'd0));
  endtask

  initial begin
    int wait_cycles;
    req.valid = 1'b0;
    req.action = ACT_BYTE;
    req.text_byte = '0;
    req.entry_index = '0;
    rsp.ready = 1'b0;
    n_distinct = 0;
    n_tokens = 0;
    tok_clean = 0;
    tok_raw = 0;
    tok_open = 1'b0;

    // directed: mixed case, punctuation-only token, read miss, unused action
    push_word("Hi, hi!");
    pending_reqs.push_back(mk_req(ACT_BYTE, 8'd13, 10'd0));
    push_word("--");
    pending_reqs.push_back(mk_req(ACT_BYTE, 8'hFF, 10'd0));
    pending_reqs.push_back(mk_req(ACT_NONE, 8'h00, 10'h3FF));
    pending_reqs.push_back(mk_req(ACT_END, 8'hFF, 10'h3FF));
    pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 10'd0));
    pending_reqs.push_back(mk_req(ACT_READ, 8'hFF, 10'h3FF));
    // token cut at the raw length limit, then a long word read back
    for (int i = 0; i < WCH + 3; i++)
      pending_reqs.push_back(mk_req(ACT_BYTE, 8'("A" + (i % 26)), 10'd0));
    pending_reqs.push_back(mk_req(ACT_END, 8'h00, 10'd0));
    pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 10'd1));
    pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 10'd2));

    // random part, filled up to about 120 items in total
    while (pending_reqs.size() < 111) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk_req(ACT_END, 8'($urandom), 10'($urandom)));
        1, 2: pending_reqs.push_back(mk_req(ACT_READ, 8'($urandom),
                                            10'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                                     : $urandom_range(0, 1023))));
        3: pending_reqs.push_back(mk_req(ACT_NONE, 8'($urandom), 10'($urandom)));
        default: push_random_word();
      endcase
    end
    pending_reqs.push_back(mk_req(ACT_END, 8'h00, 10'd0));
    for (int i = 0; i < 8; i++) pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 10'(i)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0);
    while (expected_rsps.size() != 0 || req.valid) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("word_frequency_counter_tb OK");
    end else begin
      $display("word_frequency_counter_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
